// ===== rtl/core/lge_pkg.sv =====
// ----------------------------------------------------------------------------
// lge_pkg: shared definitions for the Life generation engine
// Field widths, operation codes, default grid size and the command/status
// bundles that pass between the controller and the datapath.
// ----------------------------------------------------------------------------
package lge_pkg;

   // Fixed transaction field widths
   localparam int OP_W   = 2;
   localparam int IDX_W  = 6;
   localparam int CELL_W = 64;

   // Default grid size
   localparam int ROWS_DEFAULT = 64;
   localparam int COLS_DEFAULT = 64;

   // Operation codes
   localparam logic [OP_W-1:0] OP_LOAD    = 2'd0;
   localparam logic [OP_W-1:0] OP_ADVANCE = 2'd1;
   localparam logic [OP_W-1:0] OP_READ    = 2'd2;

   // Controller to datapath commands
   typedef struct packed {
      logic capture;      // latch row index and cells of the accepted transaction
      logic ptr_clear;    // zero the row pointer
      logic ptr_step;     // advance the row pointer
      logic addr_ptr;     // address the grid with the row pointer, else the row index
      logic clear_write;  // write a dead row at the pointer
      logic load_write;   // write the latched cells at the row index
      logic adv_start;    // reset window and live-row count for a new generation
      logic adv_read;     // sweep read of one row during an advance
      logic adv_tail;     // compute the last row with an empty row below, swap banks
      logic respond;      // register a result
      logic resp_read;    // result carries the row just read
   } cmd_type;

   // Datapath to controller status
   typedef struct packed {
      logic ptr_last;      // row pointer is at the last row
      logic idx_in_range;  // requested row index lies inside the grid
   } status_type;

endpackage

// ===== rtl/core/lge_ram.sv =====
// ----------------------------------------------------------------------------
// lge_ram: generic single-port-write, single-port-read RAM
// One write and one registered read per cycle.
// ----------------------------------------------------------------------------
module lge_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/core/lge_datapath.sv =====
// ----------------------------------------------------------------------------
// lge_datapath: grid storage, row window and B3/S23 rule
// Two row banks swap roles each generation; a three-row window feeds a
// row-wide neighbour count; a counter tracks rows holding live cells.
// ----------------------------------------------------------------------------
module lge_datapath #(
   parameter int ROWS = lge_pkg::ROWS_DEFAULT,
   parameter int COLS = lge_pkg::COLS_DEFAULT
) (
   input  logic                         clock,
   input  logic                         reset,
   input  lge_pkg::cmd_type             cmd,
   output lge_pkg::status_type          status,
   input  logic [lge_pkg::IDX_W-1:0]    req_row_index,
   input  logic [lge_pkg::CELL_W-1:0]   req_row_cells,
   output logic                         rsp_strobe,
   output logic [lge_pkg::CELL_W-1:0]   rsp_read_cells,
   output logic                         rsp_any_alive
);

   localparam int ROW_W  = $clog2(ROWS);
   localparam int CNT_W  = $clog2(ROWS + 1);
   localparam int CELL_W = lge_pkg::CELL_W;

   logic [ROW_W-1:0]  ptr_ff;
   logic [ROW_W-1:0]  idx_ff;
   logic [COLS-1:0]   cells_ff;
   logic              sel_ff;
   logic [COLS-1:0]   up_ff;
   logic [COLS-1:0]   mid_ff;
   logic              rd_vld_ff;
   logic [ROW_W-1:0]  rd_row_ff;
   logic [CNT_W-1:0]  cnt_ff;
   logic              rsp_strobe_ff;
   logic [CELL_W-1:0] rsp_cells_ff;
   logic              rsp_alive_ff;

   logic [ROW_W-1:0]  rd_addr;
   logic [COLS-1:0]   rd0_data;
   logic [COLS-1:0]   rd1_data;
   logic [COLS-1:0]   rdata_live;

   logic              live_we;
   logic [ROW_W-1:0]  live_waddr;
   logic [COLS-1:0]   live_wdata;
   logic              adv_we;
   logic [ROW_W-1:0]  adv_waddr;

   logic              bank0_we;
   logic [ROW_W-1:0]  bank0_waddr;
   logic [COLS-1:0]   bank0_wdata;
   logic              bank1_we;
   logic [ROW_W-1:0]  bank1_waddr;
   logic [COLS-1:0]   bank1_wdata;

   logic [COLS+1:0]   up_x;
   logic [COLS+1:0]   mid_x;
   logic [COLS+1:0]   dn_x;
   logic [3:0]        nbr_cnt;
   logic [COLS-1:0]   next_row;
   logic              old_nz;
   logic              new_nz;

   // Status back to the controller
   assign status.ptr_last     = (ptr_ff == ROW_W'(ROWS - 1));
   assign status.idx_in_range = (int'(req_row_index) < ROWS);

   // Address and bank steering
   assign rd_addr    = cmd.addr_ptr ? ptr_ff : idx_ff;
   assign rdata_live = sel_ff ? rd1_data : rd0_data;

   assign live_we    = cmd.clear_write || cmd.load_write;
   assign live_waddr = cmd.clear_write ? ptr_ff : idx_ff;
   assign live_wdata = cmd.clear_write ? '0 : cells_ff;

   assign adv_we    = (rd_vld_ff && (rd_row_ff != '0)) || cmd.adv_tail;
   assign adv_waddr = cmd.adv_tail ? ROW_W'(ROWS - 1) : (rd_row_ff - 1'b1);

   assign bank0_we    = sel_ff ? adv_we    : live_we;
   assign bank0_waddr = sel_ff ? adv_waddr : live_waddr;
   assign bank0_wdata = sel_ff ? next_row  : live_wdata;
   assign bank1_we    = sel_ff ? live_we    : adv_we;
   assign bank1_waddr = sel_ff ? live_waddr : adv_waddr;
   assign bank1_wdata = sel_ff ? live_wdata : next_row;

   lge_ram #(
      .WIDTH (COLS),
      .DEPTH (ROWS)
   ) u_bank0 (
      .clock   (clock),
      .wr_en   (bank0_we),
      .wr_addr (bank0_waddr),
      .wr_data (bank0_wdata),
      .rd_addr (rd_addr),
      .rd_data (rd0_data)
   );

   lge_ram #(
      .WIDTH (COLS),
      .DEPTH (ROWS)
   ) u_bank1 (
      .clock   (clock),
      .wr_en   (bank1_we),
      .wr_addr (bank1_waddr),
      .wr_data (bank1_wdata),
      .rd_addr (rd_addr),
      .rd_data (rd1_data)
   );

   // B3/S23 rule over one row; columns outside the grid are dead
   always_comb begin
      up_x     = {1'b0, up_ff, 1'b0};
      mid_x    = {1'b0, mid_ff, 1'b0};
      dn_x     = cmd.adv_tail ? '0 : {1'b0, rdata_live, 1'b0};
      nbr_cnt  = '0;
      next_row = '0;
      for (int c = 0; c < COLS; c++) begin
         nbr_cnt = 4'(up_x[c]) + 4'(up_x[c+1]) + 4'(up_x[c+2])
                 + 4'(mid_x[c]) + 4'(mid_x[c+2])
                 + 4'(dn_x[c]) + 4'(dn_x[c+1]) + 4'(dn_x[c+2]);
         next_row[c] = (nbr_cnt == 4'd3) || ((nbr_cnt == 4'd2) && mid_ff[c]);
      end
   end

   assign old_nz = (rdata_live != '0);
   assign new_nz = (cells_ff != '0);

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         ptr_ff        <= '0;
         sel_ff        <= 1'b0;
         rd_vld_ff     <= 1'b0;
         cnt_ff        <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         rd_vld_ff     <= cmd.adv_read;
         rsp_strobe_ff <= cmd.respond;

         if (cmd.ptr_clear) begin
            ptr_ff <= '0;
         end else if (cmd.ptr_step) begin
            ptr_ff <= status.ptr_last ? '0 : (ptr_ff + 1'b1);
         end

         // Swap the live and next banks once the last row is written
         if (cmd.adv_tail) begin
            sel_ff <= ~sel_ff;
         end

         if (cmd.adv_start) begin
            cnt_ff <= '0;
         end else if (adv_we) begin
            if (next_row != '0) begin
               cnt_ff <= cnt_ff + CNT_W'(1);
            end
         end else if (cmd.load_write) begin
            if (new_nz && !old_nz) begin
               cnt_ff <= cnt_ff + CNT_W'(1);
            end else if (!new_nz && old_nz) begin
               cnt_ff <= cnt_ff - CNT_W'(1);
            end
         end
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         idx_ff   <= ROW_W'(req_row_index);
         cells_ff <= req_row_cells[COLS-1:0];
      end
      if (cmd.adv_start) begin
         up_ff  <= '0;
         mid_ff <= '0;
      end else if (rd_vld_ff) begin
         up_ff  <= mid_ff;
         mid_ff <= rdata_live;
      end
      if (cmd.adv_read) begin
         rd_row_ff <= ptr_ff;
      end
      if (cmd.respond) begin
         rsp_cells_ff <= cmd.resp_read ? CELL_W'(rdata_live) : '0;
         rsp_alive_ff <= (cnt_ff != '0);
      end
   end

   assign rsp_strobe     = rsp_strobe_ff;
   assign rsp_read_cells = rsp_cells_ff;
   assign rsp_any_alive  = rsp_alive_ff;

endmodule

// ===== rtl/core/lge_ctrl.sv =====
// ----------------------------------------------------------------------------
// lge_ctrl: sequencing controller for the Life generation engine
// Runs the clearing pass after reset and steps each transaction through
// its read, write, sweep and response phases.
// ----------------------------------------------------------------------------
module lge_ctrl (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   input  logic [lge_pkg::OP_W-1:0]   req_operation,
   input  lge_pkg::status_type        status,
   output lge_pkg::cmd_type           cmd,
   output logic                       busy
);

   localparam logic [3:0] ST_IDLE      = 4'd0;
   localparam logic [3:0] ST_CLEAR     = 4'd1;
   localparam logic [3:0] ST_LOAD_RD   = 4'd2;
   localparam logic [3:0] ST_LOAD_WR   = 4'd3;
   localparam logic [3:0] ST_READ_RD   = 4'd4;
   localparam logic [3:0] ST_READ_DATA = 4'd5;
   localparam logic [3:0] ST_ADV_RD    = 4'd6;
   localparam logic [3:0] ST_ADV_DRAIN = 4'd7;
   localparam logic [3:0] ST_ADV_TAIL  = 4'd8;
   localparam logic [3:0] ST_RESP      = 4'd9;

   logic [3:0] state_ff;
   logic [3:0] state_in;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               cmd.capture = 1'b1;
               case (req_operation)
                  lge_pkg::OP_LOAD: begin
                     state_in = status.idx_in_range ? ST_LOAD_RD : ST_RESP;
                  end
                  lge_pkg::OP_ADVANCE: begin
                     cmd.ptr_clear = 1'b1;
                     cmd.adv_start = 1'b1;
                     state_in      = ST_ADV_RD;
                  end
                  lge_pkg::OP_READ: begin
                     state_in = status.idx_in_range ? ST_READ_RD : ST_RESP;
                  end
                  default: begin
                     state_in = ST_RESP;
                  end
               endcase
            end
         end
         ST_CLEAR: begin
            cmd.addr_ptr    = 1'b1;
            cmd.clear_write = 1'b1;
            cmd.ptr_step    = 1'b1;
            if (status.ptr_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_LOAD_RD: begin
            state_in = ST_LOAD_WR;
         end
         ST_LOAD_WR: begin
            cmd.load_write = 1'b1;
            state_in       = ST_RESP;
         end
         ST_READ_RD: begin
            state_in = ST_READ_DATA;
         end
         ST_READ_DATA: begin
            cmd.respond   = 1'b1;
            cmd.resp_read = 1'b1;
            state_in      = ST_IDLE;
         end
         ST_ADV_RD: begin
            cmd.addr_ptr = 1'b1;
            cmd.adv_read = 1'b1;
            cmd.ptr_step = 1'b1;
            if (status.ptr_last) begin
               state_in = ST_ADV_DRAIN;
            end
         end
         ST_ADV_DRAIN: begin
            state_in = ST_ADV_TAIL;
         end
         ST_ADV_TAIL: begin
            cmd.adv_tail = 1'b1;
            state_in     = ST_RESP;
         end
         ST_RESP: begin
            cmd.respond = 1'b1;
            state_in    = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   assign busy = (state_ff != ST_IDLE);

endmodule

// ===== rtl/core/life_generation_engine.sv =====
// ----------------------------------------------------------------------------
// life_generation_engine: bounded Game of Life grid, rule B3/S23
// Holds a ROWS-by-COLS grid, one bit per cell, bit c of a row is column c;
// cells past the edge count as dead and the grid does not wrap. Issue a
// transaction by raising start while busy is low: operation 0 loads
// req_row_cells into row req_row_index, 1 advances one generation, 2 reads
// a row; a row index outside the grid is dropped, an unused code changes
// nothing. Each transaction yields exactly one result, shown for a single
// cycle with rsp_strobe high; the receiver cannot stall it, so capture it
// on that cycle. rsp_read_cells holds the row read (zero otherwise) and
// rsp_any_alive tells whether any cell lives after the transaction. An
// advance sweeps the grid, reading one row per cycle from the read port of
// the live grid bank. After reset, busy stays high while a clearing pass
// kills every cell.
// ----------------------------------------------------------------------------
module life_generation_engine #(
   parameter int ROWS = lge_pkg::ROWS_DEFAULT,
   parameter int COLS = lge_pkg::COLS_DEFAULT
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   output logic                        busy,
   input  logic [lge_pkg::OP_W-1:0]    req_operation,
   input  logic [lge_pkg::IDX_W-1:0]   req_row_index,
   input  logic [lge_pkg::CELL_W-1:0]  req_row_cells,
   output logic                        rsp_strobe,
   output logic [lge_pkg::CELL_W-1:0]  rsp_read_cells,
   output logic                        rsp_any_alive
);

   lge_pkg::cmd_type    cmd;
   lge_pkg::status_type status;

   // Sequence each transaction: clearing pass, load, read and generation sweep
   lge_ctrl u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .req_operation (req_operation),
      .status        (status),
      .cmd           (cmd),
      .busy          (busy)
   );

   // Hold the grid banks, the row window, the rule and the result register
   lge_datapath #(
      .ROWS (ROWS),
      .COLS (COLS)
   ) u_datapath (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .status         (status),
      .req_row_index  (req_row_index),
      .req_row_cells  (req_row_cells),
      .rsp_strobe     (rsp_strobe),
      .rsp_read_cells (rsp_read_cells),
      .rsp_any_alive  (rsp_any_alive)
   );

endmodule
